[src/pgb_pkg.sv]
// Package for the proportional glyph blitter: sizes, function and register codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package pgb_pkg;

    localparam int FONT_BYTES     = 16384;
    localparam int SCREEN_ROWS    = 200;
    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPHS         = 256;

    localparam int BMP_AW = $clog2(FONT_BYTES);
    localparam int TBL_AW = $clog2(GLYPHS);

    // Function codes of an input request
    localparam logic [1:0] FN_LOAD_DESC = 2'd0;
    localparam logic [1:0] FN_LOAD_BYTE = 2'd1;
    localparam logic [1:0] FN_START     = 2'd2;
    localparam logic [1:0] FN_DRAW      = 2'd3;

    // Configuration register indices
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd0;
    localparam logic [2:0] REG_ROW_STRIDE   = 3'd1;
    localparam logic [2:0] REG_INK_COLOR    = 3'd2;
    localparam logic [2:0] REG_WORD_SPACE   = 3'd3;
    localparam logic [2:0] REG_LETTER_SPACE = 3'd4;

    // Result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;      // latch request, perform loads and pen start
        logic       desc_ld;   // capture descriptor, restart row walk
        logic [1:0] rd_sel;    // byte offset from row base to read
        logic [2:0] byte_ld;   // capture returned bitmap byte
        logic       row_emit;  // present row mask, step to next row
        logic       halt_set;  // stop at screen bottom
        logic       pen_adv;   // advance pen after glyph
        logic       done_emit; // present done result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       halted;
        logic       zero_w;
        logic       rows_done;
        logic       bottom;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

[src/pgb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module pgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/pgb_ctrl.sv]
// Controller for the glyph blitter: sequences table lookup, row byte reads and result
// hand-off. Depends on pgb_pkg.
`default_nettype none
module pgb_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  pgb_pkg::t_sts       i_sts,
    output pgb_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TBL  = 4'd1;
    localparam logic [3:0] S_DESC = 4'd2;
    localparam logic [3:0] S_ZCHK = 4'd3;
    localparam logic [3:0] S_ROW  = 4'd4;
    localparam logic [3:0] S_RD1  = 4'd5;
    localparam logic [3:0] S_RD2  = 4'd6;
    localparam logic [3:0] S_RD3  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.func == pgb_pkg::FN_DRAW && !i_sts.halted) begin
                        n_state = S_TBL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TBL:  n_state = S_DESC;
            S_DESC: begin
                o_cmd.desc_ld = 1'b1;
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                if (i_sts.zero_w) begin
                    o_cmd.pen_adv = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (i_sts.rows_done) begin
                    o_cmd.pen_adv = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.bottom) begin
                    o_cmd.halt_set = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel = 2'd0;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd_sel  = 2'd1;
                o_cmd.byte_ld = 3'b001;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_sel  = 2'd2;
                o_cmd.byte_ld = 3'b010;
                n_state = S_RD3;
            end
            S_RD3: begin
                o_cmd.byte_ld = 3'b100;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.row_emit = 1'b1;
                    n_state = S_ROW;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.done_emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[src/pgb_dp.sv]
// Datapath for the glyph blitter: config registers, pen, font memories, row mask
// assembly and the output register. Depends on pgb_pkg and pgb_ram.
`default_nettype none
module pgb_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_idx,
    input  wire [11:0]          i_cfg_data,
    input  wire [1:0]           i_func,
    input  wire [13:0]          i_addr,
    input  wire [15:0]          i_data,
    input  wire signed [15:0]   i_pos_x,
    input  wire signed [15:0]   i_pos_y,
    input  wire                 i_stall,
    output logic                o_valid,
    output logic                o_kind,
    output logic signed [15:0]  o_row_y,
    output logic signed [15:0]  o_col_x,
    output logic [14:0]         o_pixel_mask,
    output logic [7:0]          o_color,
    output logic                o_halted,
    output logic                o_last,
    input  pgb_pkg::t_cmd       i_cmd,
    output pgb_pkg::t_sts       o_sts
);

    logic [5:0]  r_height;
    logic [11:0] r_stride;
    logic [7:0]  r_ink;
    logic [5:0]  r_word;
    logic [5:0]  r_letter;

    logic [15:0] r_pen_x;
    logic [15:0] r_pen_y;
    logic        r_halt;

    logic [pgb_pkg::TBL_AW-1:0] r_code;
    logic [3:0]                 r_w;
    logic [2:0]                 r_bitpos;
    logic [pgb_pkg::BMP_AW-1:0] r_base;
    logic [5:0]                 r_row;
    logic [7:0]                 r_byte [3];

    logic [15:0]                tbl_rdata;
    logic [7:0]                 bmp_rdata;
    logic [pgb_pkg::BMP_AW-1:0] bmp_raddr;

    logic [5:0]         rows_eff;
    logic signed [16:0] row_y;
    logic [23:0]        bits;
    logic [14:0]        mask;
    logic [6:0]         adv;
    logic               out_free;

    // Font memories: descriptors and bitmap bytes
    pgb_ram #(.WIDTH(16), .DEPTH(pgb_pkg::GLYPHS)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && i_func == pgb_pkg::FN_LOAD_DESC),
        .i_waddr (i_addr[pgb_pkg::TBL_AW-1:0]),
        .i_wdata (i_data),
        .i_raddr (r_code),
        .o_rdata (tbl_rdata)
    );

    assign bmp_raddr = r_base + pgb_pkg::BMP_AW'(i_cmd.rd_sel);

    pgb_ram #(.WIDTH(8), .DEPTH(pgb_pkg::FONT_BYTES)) u_bmp (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && i_func == pgb_pkg::FN_LOAD_BYTE),
        .i_waddr (i_addr[pgb_pkg::BMP_AW-1:0]),
        .i_wdata (i_data[7:0]),
        .i_raddr (bmp_raddr),
        .o_rdata (bmp_rdata)
    );

    // Row count, screen row and row mask
    assign rows_eff = (r_height > 6'(pgb_pkg::MAX_GLYPH_ROWS)) ?
                      6'(pgb_pkg::MAX_GLYPH_ROWS) : r_height;
    assign row_y    = 17'(signed'(r_pen_y)) + 17'(r_row);
    assign bits     = {r_byte[0], r_byte[1], r_byte[2]} << r_bitpos;

    always_comb begin
        for (int i = 0; i < 15; i++) begin
            mask[i] = (4'(i) < r_w) ? bits[23-i] : 1'b0;
        end
    end

    assign adv      = ((r_w == 4'd0) ? {1'b0, r_word} : {3'd0, r_w}) + {1'b0, r_letter};
    assign out_free = !o_valid || !i_stall;

    // Status
    assign o_sts.func      = i_func;
    assign o_sts.halted    = r_halt;
    assign o_sts.zero_w    = (r_w == 4'd0);
    assign o_sts.rows_done = (r_row >= rows_eff);
    assign o_sts.bottom    = (row_y >= $signed(17'(pgb_pkg::SCREEN_ROWS)));
    assign o_sts.out_free  = out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 6'd16;
            r_stride <= 12'd16;
            r_ink    <= 8'd0;
            r_word   <= 6'd2;
            r_letter <= 6'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pgb_pkg::REG_GLYPH_HEIGHT: r_height <= i_cfg_data[5:0];
                pgb_pkg::REG_ROW_STRIDE:   r_stride <= i_cfg_data;
                pgb_pkg::REG_INK_COLOR:    r_ink    <= i_cfg_data[7:0];
                pgb_pkg::REG_WORD_SPACE:   r_word   <= i_cfg_data[5:0];
                pgb_pkg::REG_LETTER_SPACE: r_letter <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Pen and halt flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_halt  <= 1'b0;
        end else begin
            if (i_cmd.take && i_func == pgb_pkg::FN_START) begin
                r_pen_x <= i_pos_x;
                r_pen_y <= i_pos_y;
                r_halt  <= 1'b0;
            end
            if (i_cmd.pen_adv) begin
                r_pen_x <= r_pen_x + 16'(adv);
            end
            if (i_cmd.halt_set) begin
                r_halt <= 1'b1;
            end
        end
    end

    // Glyph walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_code <= i_addr[pgb_pkg::TBL_AW-1:0];
        end
        if (i_cmd.desc_ld) begin
            r_w      <= tbl_rdata[15:12];
            r_bitpos <= tbl_rdata[2:0];
            r_base   <= pgb_pkg::BMP_AW'(tbl_rdata[11:3]);
            r_row    <= '0;
        end
        if (i_cmd.row_emit) begin
            r_row  <= r_row + 6'd1;
            r_base <= r_base + pgb_pkg::BMP_AW'(r_stride);
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.byte_ld[k]) begin
                r_byte[k] <= bmp_rdata;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.row_emit || i_cmd.done_emit) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_emit) begin
            o_kind       <= pgb_pkg::KIND_ROW;
            o_row_y      <= row_y[15:0];
            o_col_x      <= r_pen_x;
            o_pixel_mask <= mask;
            o_color      <= r_ink;
            o_halted     <= 1'b0;
            o_last       <= 1'b0;
        end else if (i_cmd.done_emit) begin
            o_kind       <= pgb_pkg::KIND_DONE;
            o_row_y      <= r_pen_y;
            o_col_x      <= r_pen_x;
            o_pixel_mask <= '0;
            o_color      <= '0;
            o_halted     <= r_halt;
            o_last       <= 1'b1;
        end
    end

endmodule
`default_nettype wire

[src/proportional_glyph_blitter_core.sv]
// Top level of the proportional glyph blitter: controller plus datapath.
// Depends on pgb_pkg, pgb_ctrl, pgb_dp and pgb_ram.
`default_nettype none
// Draws characters of a proportional bitmap font as one pixel-mask result per glyph
// row, and ends every request with a done result carrying the pen. Requests are taken
// one at a time. Loads and pen starts pass through the accept and the done hand-off.
// A character looks up its descriptor; then, with the output free, each glyph row reads
// three bitmap bytes through the single read port of the bitmap RAM, one a cycle,
// then presents its mask. A zero-width glyph skips the rows. Output stalls hold the walk.
// A finished result waits in the output register while the next request is taken.
module proportional_glyph_blitter_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_idx,
    input  wire [11:0]          i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire [1:0]           i_func,
    input  wire [13:0]          i_addr,
    input  wire [15:0]          i_data,
    input  wire signed [15:0]   i_pos_x,
    input  wire signed [15:0]   i_pos_y,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic                o_kind,
    output logic signed [15:0]  o_row_y,
    output logic signed [15:0]  o_col_x,
    output logic [14:0]         o_pixel_mask,
    output logic [7:0]          o_color,
    output logic                o_halted,
    output logic                o_last
);

    pgb_pkg::t_cmd cmd;
    pgb_pkg::t_sts sts;

    pgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pgb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_addr       (i_addr),
        .i_data       (i_data),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_row_y      (o_row_y),
        .o_col_x      (o_col_x),
        .o_pixel_mask (o_pixel_mask),
        .o_color      (o_color),
        .o_halted     (o_halted),
        .o_last       (o_last),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

`ifndef SYNTH
    // Row masks are never final and done results are
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_kind))
        else $error("last flag disagrees with result kind");

    // Done results carry no pixels
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == pgb_pkg::KIND_DONE) |-> (o_pixel_mask == '0))
        else $error("done result with pixel mask");

    // Nothing is presented straight after reset
    assert property (@(posedge i_clk) (i_rst_n && $past(!i_rst_n)) |-> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
